// File: rtl/core/thc_pkg.sv
// ----------------------------------------------------------------------------
// thc_pkg
// Shared constants, status codes and types for the tar header checker.
// ----------------------------------------------------------------------------
`default_nettype none

package thc_pkg;

  localparam int unsigned HdrBytes   = 512;
  localparam int unsigned IdxW       = 9;
  localparam int unsigned SizeW      = 36;
  localparam int unsigned OffW       = 32;
  localparam int unsigned StatW      = 3;

  localparam logic [IdxW-1:0] IDX_LAST   = 9'd511;
  localparam logic [IdxW-1:0] SIG_START  = 9'd257;
  localparam logic [IdxW-1:0] SIG_END    = 9'd263;  // one past the last signature byte
  localparam logic [IdxW-1:0] NAME_END   = 9'd99;
  localparam logic [IdxW-1:0] SIZE_START = 9'd124;
  localparam logic [IdxW-1:0] SIZE_END   = 9'd136;  // one past the last size digit

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SEVEN = 8'h37;

  localparam logic [StatW-1:0] ST_OK        = 3'd0;
  localparam logic [StatW-1:0] ST_END       = 3'd1;
  localparam logic [StatW-1:0] ST_PARTIAL   = 3'd2;
  localparam logic [StatW-1:0] ST_BAD_SIG   = 3'd3;
  localparam logic [StatW-1:0] ST_NAME_UNT  = 3'd4;
  localparam logic [StatW-1:0] ST_BAD_DIGIT = 3'd5;
  localparam logic [StatW-1:0] ST_SIZE_BIG  = 3'd6;

  // Summary of one finished header, handed from the byte scanner to the
  // result stage.
  typedef struct packed {
    logic             any_nonzero;
    logic             signature_ok;
    logic             name_terminated;
    logic             digit_error;
    logic [SizeW-1:0] size;
  } hdr_summary_t;

  // Expected "ustar" plus terminating zero, by position in the signature.
  function automatic logic [7:0] sig_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = 8'h75;  // u
      3'd1:    b = 8'h73;  // s
      3'd2:    b = 8'h74;  // t
      3'd3:    b = 8'h61;  // a
      3'd4:    b = 8'h72;  // r
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/thc_byte_scan.sv
// ----------------------------------------------------------------------------
// thc_byte_scan
// Per-byte scan of a header: position counter and running checks.
// ----------------------------------------------------------------------------
`default_nettype none

module thc_byte_scan (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    byte_go,
  input  wire logic [7:0]              byte_in,
  output logic                         last,
  output thc_pkg::hdr_summary_t        summary
);
  import thc_pkg::*;

  logic [IdxW-1:0]  byte_index;
  logic             any_nonzero;
  logic             signature_ok;
  logic             name_terminated;
  logic [SizeW-1:0] size_accumulator;
  logic             size_field_ended;
  logic             digit_error;

  logic             any_nonzero_next;
  logic             signature_ok_next;
  logic             name_terminated_next;
  logic [SizeW-1:0] size_accumulator_next;
  logic             size_field_ended_next;
  logic             digit_error_next;

  logic             nz;
  logic             in_sig;
  logic             in_size;
  logic             is_digit;
  logic [IdxW-1:0]  sig_off;

  assign last    = (byte_index == IDX_LAST);
  assign nz      = (byte_in != 8'd0);
  assign in_sig  = (byte_index >= SIG_START) && (byte_index < SIG_END);
  assign in_size = (byte_index >= SIZE_START) && (byte_index < SIZE_END) && !size_field_ended;
  assign is_digit = (byte_in >= CHAR_ZERO) && (byte_in <= CHAR_SEVEN);
  assign sig_off = byte_index - SIG_START;

  always_comb begin
    any_nonzero_next      = any_nonzero | nz;
    signature_ok_next     = signature_ok;
    name_terminated_next  = name_terminated;
    size_accumulator_next = size_accumulator;
    size_field_ended_next = size_field_ended;
    digit_error_next      = digit_error;
    if (in_sig && (byte_in != sig_byte(sig_off[2:0]))) begin
      signature_ok_next = 1'b0;
    end
    if ((byte_index == NAME_END) && nz) begin
      name_terminated_next = 1'b0;
    end
    if (in_size) begin
      if (!nz) begin
        size_field_ended_next = 1'b1;
      end else if (!is_digit) begin
        digit_error_next = 1'b1;
      end else begin
        size_accumulator_next = {size_accumulator[SizeW-4:0], byte_in[2:0]};
      end
    end
  end

  assign summary = '{any_nonzero:     any_nonzero_next,
                     signature_ok:    signature_ok_next,
                     name_terminated: name_terminated_next,
                     digit_error:     digit_error_next,
                     size:            size_accumulator_next};

  // Clear per-header state after the last byte.
  always_ff @(posedge clk) begin
    if (rst || (byte_go && last)) begin
      byte_index       <= '0;
      any_nonzero      <= 1'b0;
      signature_ok     <= 1'b1;
      name_terminated  <= 1'b1;
      size_accumulator <= '0;
      size_field_ended <= 1'b0;
      digit_error      <= 1'b0;
    end else if (byte_go) begin
      byte_index       <= byte_index + 9'd1;
      any_nonzero      <= any_nonzero_next;
      signature_ok     <= signature_ok_next;
      name_terminated  <= name_terminated_next;
      size_accumulator <= size_accumulator_next;
      size_field_ended <= size_field_ended_next;
      digit_error      <= digit_error_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tar_header_checker_core.sv
// ----------------------------------------------------------------------------
// tar_header_checker_core
// Streaming ustar header checker with archive offset tracking.
// ----------------------------------------------------------------------------
// Header bytes enter one per cycle on the header_byte channel, byte 0 first,
// 512 bytes per header, with no gaps needed between headers. After byte 511
// one result request leaves on the result channel. With the output free, that
// byte passes the input register, is folded into the scan and lands in the
// summary register, then the decision lands in the output register.
// Sustained rate is one byte per cycle; the input stalls only when byte 511 of
// a header reaches the scan while the previous header's summary still waits
// behind an untaken result. Writing archive_length sets the archive size and
// rewinds the offset to zero; write only while no header is in progress and
// no result is pending.
`default_nettype none

module tar_header_checker_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        archive_length_we,
  input  wire logic [thc_pkg::OffW-1:0]    archive_length,
  input  wire logic                        header_byte_valid,
  output logic                             header_byte_ready,
  input  wire logic [7:0]                  header_byte,
  output logic                             result_valid,
  input  wire logic                        result_ready,
  output logic [thc_pkg::StatW-1:0]        status,
  output logic [thc_pkg::SizeW-1:0]        entry_size,
  output logic [thc_pkg::OffW-1:0]         next_offset
);
  import thc_pkg::*;

  // Input register.
  logic       a_valid;
  logic [7:0] a_byte;

  // Scanner interface.
  logic         b_go;
  logic         scan_last;
  hdr_summary_t scan_summary;

  // Finished header summary, waiting for the result stage.
  logic         fin_valid;
  hdr_summary_t fin;
  logic         fin_move;

  // Archive position: current offset and bytes left from it.
  logic [OffW-1:0] archive_offset;
  logic [OffW-1:0] left;

  // Result stage.
  logic             left_zero;
  logic             left_small;
  logic [OffW-1:0]  room;
  logic             too_big;
  logic [StatW-1:0] status_next;
  logic [SizeW-1:0] entry_size_next;
  logic [OffW-1:0]  advanced;

  // Drain the summary whenever the output register is free or being taken.
  assign fin_move = fin_valid && (!result_valid || result_ready);

  // Advance a byte into the scanner unless it closes a header and the
  // previous summary cannot move on yet.
  assign b_go = a_valid && !(scan_last && fin_valid && !fin_move);
  assign header_byte_ready = !a_valid || b_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (header_byte_ready) begin
      a_valid <= header_byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (header_byte_ready && header_byte_valid) begin
      a_byte <= header_byte;
    end
  end

  thc_byte_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .byte_go (b_go),
    .byte_in (a_byte),
    .last    (scan_last),
    .summary (scan_summary)
  );

  // Capture the summary of a completed header.
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (b_go && scan_last) begin
      fin_valid <= 1'b1;
    end else if (fin_move) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && scan_last) begin
      fin <= scan_summary;
    end
  end

  // Status decision, in priority order. The size check compares against
  // left - 512, formed by decrementing the upper bits only.
  assign left_zero  = (left == '0);
  assign left_small = (left[OffW-1:9] == '0);
  assign room       = {left[OffW-1:9] - 23'd1, left[8:0]};
  assign too_big    = (fin.size > {{(SizeW-OffW){1'b0}}, room});
  assign advanced   = archive_offset + 32'(HdrBytes) + fin.size[OffW-1:0];

  always_comb begin
    entry_size_next = '0;
    if (left_zero) begin
      status_next = ST_END;
    end else if (left_small) begin
      status_next = ST_PARTIAL;
    end else if (!fin.any_nonzero) begin
      status_next = ST_END;
    end else if (!fin.signature_ok) begin
      status_next = ST_BAD_SIG;
    end else if (!fin.name_terminated) begin
      status_next = ST_NAME_UNT;
    end else if (fin.digit_error) begin
      status_next = ST_BAD_DIGIT;
    end else if (too_big) begin
      status_next     = ST_SIZE_BIG;
      entry_size_next = fin.size;
    end else begin
      status_next     = ST_OK;
      entry_size_next = fin.size;
    end
  end

  // Hold the archive position; advance it only on a good entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      archive_offset <= '0;
      left           <= '0;
    end else if (archive_length_we) begin
      archive_offset <= '0;
      left           <= archive_length;
    end else if (fin_move && (status_next == ST_OK)) begin
      archive_offset <= advanced;
      left           <= left - 32'(HdrBytes) - fin.size[OffW-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fin_move) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_move) begin
      status      <= status_next;
      entry_size  <= entry_size_next;
      next_offset <= (status_next == ST_OK) ? advanced : archive_offset;
    end
  end

  // A pending summary is never overwritten before it moves on.
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    fin_valid && !fin_move |=> fin_valid && $stable(fin))
    else $error("header summary lost while waiting for output");

  // A completed header always yields a pending summary.
  a_fin_load: assert property (@(posedge clk) disable iff (rst)
    b_go && scan_last |=> fin_valid)
    else $error("completed header produced no summary");

  // Entry size is reported only for ok and size-too-big results.
  a_size_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != ST_OK) && (status != ST_SIZE_BIG) |-> entry_size == '0)
    else $error("entry size reported for a failed header");

  // Only one scanner advance per cycle, and only with a byte present.
  a_go_valid: assert property (@(posedge clk) disable iff (rst)
    b_go |-> a_valid && (!scan_last || !fin_valid || fin_move))
    else $error("scanner advanced without room for the summary");

endmodule

`default_nettype wire

// File: tb/sv/tar_header_checker_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tar_header_checker_core_tb
// Self-checking bench for the streaming ustar header checker. Whole 512-byte
// headers are built in the bench (well-formed ones with random content,
// broken ones and noise), streamed byte by byte under random sender gaps and
// receiver stalls, and every result is checked against a cycle-free model of
// the scan and the archive offset bookkeeping.
// ----------------------------------------------------------------------------

module tar_header_checker_core_tb;
  import thc_pkg::*;

  localparam logic [47:0] USTAR_SIG      = {"ustar", 8'h00};
  localparam int          WATCHDOG_LIMIT = 20000;
  localparam int          DRAIN_CYCLES   = 16;
  localparam int          LONG_HOLD      = 3000;
  localparam int          REPORT_MAX     = 10;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [SizeW-1:0] size;
    logic [OffW-1:0]  next_off;
  } hdr_result_t;

  // Clock, reset and DUT ports. Every input starts at a known value.
  logic             clk               = 1'b0;
  logic             rst               = 1'b1;
  logic             archive_length_we = 1'b0;
  logic [OffW-1:0]  archive_length    = '0;
  logic             header_byte_valid = 1'b0;
  logic             header_byte_ready;
  logic [7:0]       header_byte       = 8'h00;
  logic             result_valid;
  logic             result_ready      = 1'b0;
  logic [StatW-1:0] status;
  logic [SizeW-1:0] entry_size;
  logic [OffW-1:0]  next_offset;

  // Bytes waiting to be offered, and header results still to arrive.
  logic [7:0]  pending_bytes[$];
  hdr_result_t awaited_results[$];
  logic [7:0]  hdr_buf[512];

  // Mirror of the checker: archive bookkeeping plus per-header scan flags.
  logic [OffW-1:0]  arch_len   = '0;
  logic [OffW-1:0]  arch_off   = '0;
  logic [IdxW-1:0]  scan_idx   = '0;
  logic             seen_nonzero = 1'b0;
  logic             magic_ok   = 1'b1;
  logic             name_ok    = 1'b1;
  logic [SizeW-1:0] size_acc   = '0;
  logic             size_done  = 1'b0;
  logic             digit_bad  = 1'b0;

  // Traffic shaping, shared between the sequencer and the two channel ends.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_left      = 0;
  bit byte_taken     = 1'b0;

  // Bookkeeping.
  int errors          = 0;
  int idle_cycles     = 0;
  int headers_sent    = 0;
  int bytes_accepted  = 0;
  int results_checked = 0;
  int lengths_written = 0;
  int status_seen[8]  = '{default: 0};

  tar_header_checker_core DUT (
    .clk               (clk),
    .rst               (rst),
    .archive_length_we (archive_length_we),
    .archive_length    (archive_length),
    .header_byte_valid (header_byte_valid),
    .header_byte_ready (header_byte_ready),
    .header_byte       (header_byte),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .status            (status),
    .entry_size        (entry_size),
    .next_offset       (next_offset)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Header model: fold one accepted byte into the scan flags; on the last byte
  // of a header, settle the status, advance the offset on a good entry and
  // queue the result that the block must produce.
  // --------------------------------------------------------------------------
  task automatic scan_header_byte(input logic [7:0] b);
    int               k;
    logic [OffW-1:0]  left;
    hdr_result_t      r;
    k = int'(scan_idx) - int'(SIG_START);
    if (b != 8'h00) seen_nonzero = 1'b1;
    if (scan_idx >= SIG_START && scan_idx < SIG_END && b != USTAR_SIG[47 - 8*k -: 8])
      magic_ok = 1'b0;
    if (scan_idx == NAME_END && b != 8'h00) name_ok = 1'b0;
    // Size field: octal digits up to the first zero byte; bytes past it don't matter.
    if (scan_idx >= SIZE_START && scan_idx < SIZE_END && !size_done) begin
      if (b == 8'h00) size_done = 1'b1;
      else if (b < CHAR_ZERO || b > CHAR_SEVEN) digit_bad = 1'b1;
      else size_acc = {size_acc[SizeW-4:0], b[2:0]};
    end
    if (scan_idx != IDX_LAST) begin
      scan_idx = scan_idx + 1'b1;
      return;
    end

    // Saturate the remaining length at zero if the offset ever overshoots.
    left       = (arch_off <= arch_len) ? arch_len - arch_off : '0;
    r.size     = '0;
    r.next_off = arch_off;
    if (left == '0)                                   r.status = ST_END;
    else if (left < HdrBytes)                         r.status = ST_PARTIAL;
    else if (!seen_nonzero)                           r.status = ST_END;
    else if (!magic_ok)                               r.status = ST_BAD_SIG;
    else if (!name_ok)                                r.status = ST_NAME_UNT;
    else if (digit_bad)                               r.status = ST_BAD_DIGIT;
    else if (size_acc > ({4'd0, left} - 36'd512)) begin
      r.status = ST_SIZE_BIG;
      r.size   = size_acc;
    end else begin
      r.status   = ST_OK;
      r.size     = size_acc;
      r.next_off = arch_off + 32'd512 + size_acc[OffW-1:0];
      arch_off   = r.next_off;
    end
    awaited_results.push_back(r);

    // Rearm the scan for the next header.
    scan_idx     = '0;
    seen_nonzero = 1'b0;
    magic_ok     = 1'b1;
    name_ok      = 1'b1;
    size_acc     = '0;
    size_done    = 1'b0;
    digit_bad    = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Header builders. They work on hdr_buf; send_header queues it for the
  // driver.
  // --------------------------------------------------------------------------

  // Well-formed header with random filler: terminated name, the size written
  // as ndig octal digits (leading zeros allowed, zero byte after unless all
  // twelve are used), and a valid signature.
  task automatic make_header(input logic [SizeW-1:0] size, input int ndig);
    int               k;
    logic [SizeW-1:0] sh;
    for (k = 0; k < 512; k++) hdr_buf[k] = 8'($urandom_range(255));
    hdr_buf[NAME_END] = 8'h00;
    for (k = 0; k < ndig; k++) begin
      sh = size >> (3 * (ndig - 1 - k));
      hdr_buf[SIZE_START + k] = {5'b00110, sh[2:0]};
    end
    if (ndig < 12) hdr_buf[SIZE_START + ndig] = 8'h00;
    for (k = 0; k < 6; k++) hdr_buf[SIG_START + k] = USTAR_SIG[47 - 8*k -: 8];
  endtask

  task automatic fill_header(input logic [7:0] b);
    int k;
    for (k = 0; k < 512; k++) hdr_buf[k] = b;
  endtask

  // Flip one bit of one signature byte, so the byte is always wrong.
  task automatic break_signature(input int pos);
    hdr_buf[SIG_START + pos] = hdr_buf[SIG_START + pos] ^ (8'h01 << $urandom_range(7));
  endtask

  // Put a non-octal, nonzero byte into the size field; b == 0 picks one at random.
  task automatic break_digit(input int pos, input logic [7:0] b);
    logic [7:0] v;
    v = b;
    while (v == 8'h00 || (v >= CHAR_ZERO && v <= CHAR_SEVEN)) v = 8'($urandom_range(255));
    hdr_buf[SIZE_START + pos] = v;
  endtask

  task automatic send_header();
    int k;
    for (k = 0; k < 512; k++) pending_bytes.push_back(hdr_buf[k]);
    headers_sent++;
  endtask

  // Mostly well-formed headers with random sizes, plus broken ones and noise.
  task automatic random_header();
    int               pick;
    int               need;
    int               nd;
    logic [63:0]      r64;
    logic [SizeW-1:0] sz;
    logic [SizeW-1:0] t;
    pick = $urandom_range(99);
    r64  = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1, 2, 3, 4: sz = $urandom_range(2047);
      5, 6:          sz = $urandom_range(1 << 20);
      7, 8:          sz = {4'd0, r64[31:0]};
      default:       sz = r64[SizeW-1:0];
    endcase
    need = 0;
    t    = sz;
    while (t != '0) begin
      need++;
      t = t >> 3;
    end
    nd = $urandom_range(12, need);
    if (pick < 4) begin
      fill_header(8'h00);
    end else if (pick < 6) begin
      for (int k = 0; k < 512; k++) hdr_buf[k] = 8'($urandom_range(255));
    end else begin
      make_header(sz, nd);
      if (pick < 12) break_signature($urandom_range(5));
      else if (pick < 18) hdr_buf[NAME_END] = 8'($urandom_range(255, 1));
      else if (pick < 24) break_digit($urandom_range(nd < 12 ? nd : 11), 8'h00);
    end
    send_header();
  endtask

  // --------------------------------------------------------------------------
  // Sequencing helpers.
  // --------------------------------------------------------------------------

  // Write the one register; called at a falling edge while the block is idle.
  task automatic set_archive_length(input logic [OffW-1:0] v);
    archive_length_we <= 1'b1;
    archive_length    <= v;
    @(negedge clk);
    archive_length_we <= 1'b0;
    arch_len = v;
    arch_off = '0;
    lengths_written++;
  endtask

  // Wait for every queued byte to be taken and every result to come back,
  // then give the pipeline time to settle.
  task automatic drain();
    while (pending_bytes.size() != 0 || awaited_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Driver: hold the offered byte until taken, then offer the next one or
  // idle, as the current idle percentage says.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      header_byte_valid <= 1'b0;
    end else if (!header_byte_valid || byte_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        header_byte_valid <= 1'b1;
        header_byte       <= pending_bytes[0];
      end else begin
        header_byte_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off counted down here once the
  // sequencer asks for one.
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on every accepted byte, check every accepted result
  // against the oldest expectation, and run the watchdog.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    hdr_result_t exp_r;
    logic [7:0]  dropped;
    bit          moved;
    moved      = 1'b0;
    byte_taken = 1'b0;
    if (!rst && header_byte_valid && header_byte_ready) begin
      scan_header_byte(header_byte);
      dropped    = pending_bytes.pop_front();
      byte_taken = 1'b1;
      moved      = 1'b1;
      bytes_accepted++;
    end
    if (!rst && result_valid && result_ready) begin
      moved = 1'b1;
      results_checked++;
      if (awaited_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t: unexpected result status=%0d size=%h next=%h",
                   $realtime, status, entry_size, next_offset);
      end else begin
        exp_r = awaited_results.pop_front();
        status_seen[exp_r.status]++;
        if (status !== exp_r.status || entry_size !== exp_r.size ||
            next_offset !== exp_r.next_off) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("%0t: result mismatch exp status=%0d size=%h next=%h, got %0d %h %h",
                     $realtime, exp_r.status, exp_r.size, exp_r.next_off,
                     status, entry_size, next_offset);
        end
      end
    end
    if (moved) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request accepted for %0d cycles", idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: directed headers at the boundary lengths, then random phases
  // under each idling pattern, then one long receiver hold-off.
  // --------------------------------------------------------------------------
  initial begin : sequencer
    int ph;
    int sub;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Empty archive: any header reports end of archive.
    set_archive_length(32'd0);
    @(posedge clk);
    make_header(36'd0, 11);
    send_header();
    drain();

    // Largest archive: cover each check and their precedence.
    set_archive_length(32'hFFFF_FFFF);
    @(posedge clk);
    make_header(36'd0, 11);                 // empty entry
    send_header();
    make_header(36'd0, 0);                  // size field starts with its zero byte
    send_header();
    make_header(36'o1234, 12);              // all twelve digits, no terminator
    send_header();
    make_header(36'hF_FFFF_FFFF, 12);       // widest size, too big for what is left
    send_header();
    make_header(36'h0_8000_0000, 11);       // jump the offset far ahead
    send_header();
    fill_header(8'h00);                     // all-zero block
    send_header();
    fill_header(8'hFF);                     // everything wrong, signature wins
    send_header();
    for (int k = 0; k < 6; k++) begin       // each signature byte, terminator too
      make_header(36'd17, 11);
      break_signature(k);
      send_header();
    end
    make_header(36'd5, 11);                 // name runs into byte 99
    hdr_buf[NAME_END] = 8'hFF;
    send_header();
    make_header(36'd5, 11);                 // open name and bad signature together
    hdr_buf[NAME_END] = "a";
    break_signature(2);
    send_header();
    make_header(36'd100, 11);               // digit just above the octal range
    break_digit(0, "8");
    send_header();
    make_header(36'd100, 11);               // trailing space where the zero belongs
    break_digit(11, " ");
    send_header();
    make_header(36'd100, 11);               // digit just below the octal range
    break_digit(3, "/");
    send_header();
    make_header(36'd100, 11);               // open name and bad digit together
    hdr_buf[NAME_END] = 8'h01;
    break_digit(1, 8'h80);
    send_header();
    make_header(36'd5, 3);                  // junk after the size terminator is ignored
    hdr_buf[SIZE_START + 5] = "9";
    send_header();
    drain();

    // Less than one header left.
    set_archive_length(32'd300);
    @(posedge clk);
    make_header(36'd0, 11);
    send_header();
    fill_header(8'h00);
    send_header();
    drain();

    // Exactly one header: size one is too big, size zero fits, then nothing left.
    set_archive_length(32'd512);
    @(posedge clk);
    make_header(36'd1, 11);
    send_header();
    make_header(36'd0, 11);
    send_header();
    make_header(36'd0, 11);
    send_header();
    drain();

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (ph = 0; ph < 4; ph++) begin
      for (sub = 0; sub < 2; sub++) begin
        set_archive_length(sub == 0 ? $urandom : $urandom_range(12000, 200));
        @(posedge clk);
        send_idle_pct  = (ph == 1) ? 64 : (ph == 3) ? 32 : 0;
        recv_stall_pct = (ph == 2) ? 64 : (ph == 3) ? 32 : 0;
        repeat (7) random_header();
        drain();
      end
    end

    // Back-pressure: hold the result side off while the sender keeps going,
    // so the block fills and stalls its input.
    set_archive_length(32'hFFFF_FFFF);
    @(posedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = LONG_HOLD;
    repeat (8) random_header();
    drain();

    $display("Covered %0d headers (%0d bytes), %0d results, %0d archive lengths.",
             headers_sent, bytes_accepted, results_checked, lengths_written);
    $display("Statuses: ok %0d, end %0d, partial %0d, sig %0d, name %0d, digit %0d, big %0d",
             status_seen[ST_OK], status_seen[ST_END], status_seen[ST_PARTIAL],
             status_seen[ST_BAD_SIG], status_seen[ST_NAME_UNT],
             status_seen[ST_BAD_DIGIT], status_seen[ST_SIZE_BIG]);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/thc_pkg.sv
rtl/core/thc_byte_scan.sv
rtl/core/tar_header_checker_core.sv
tb/sv/tar_header_checker_core_tb.sv
